### hdl/machine_csr_file_with_trap_entry_top_assert.svh
// Assertion macros for the machine CSR file with trap entry.
`ifndef MACHINE_CSR_FILE_WITH_TRAP_ENTRY_TOP_ASSERT_SVH
`define MACHINE_CSR_FILE_WITH_TRAP_ENTRY_TOP_ASSERT_SVH
`ifndef SYNTH
`define MCSR_ASSERT_SAME(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define MCSR_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`define MCSR_ASSERT_TWO(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> ##1 (b)) else $error(msg);
`else
`define MCSR_ASSERT_SAME(label, clk, rst, a, b, msg)
`define MCSR_ASSERT_NEXT(label, clk, rst, a, b, msg)
`define MCSR_ASSERT_TWO(label, clk, rst, a, b, msg)
`endif
`endif

### hdl/mcsr_pkg.sv
// Types and constants shared by the machine CSR file modules.
package mcsr_pkg;

   typedef enum logic [2:0] {
      OP_RW         = 3'd0,
      OP_RS         = 3'd1,
      OP_RC         = 3'd2,
      OP_INST_ALIGN = 3'd3,
      OP_LOAD_ALIGN = 3'd4,
      OP_STORE_ALIGN = 3'd5,
      OP_TICK       = 3'd6
   } op_type;

   localparam logic [11:0] ADDR_CYCLE     = 12'hC00;
   localparam logic [11:0] ADDR_CYCLEH    = 12'hC80;
   localparam logic [11:0] ADDR_MSTATUS   = 12'h300;
   localparam logic [11:0] ADDR_MISA      = 12'h301;
   localparam logic [11:0] ADDR_MTVEC     = 12'h305;
   localparam logic [11:0] ADDR_MSCRATCH  = 12'h340;
   localparam logic [11:0] ADDR_MEPC      = 12'h341;
   localparam logic [11:0] ADDR_MCAUSE    = 12'h342;
   localparam logic [11:0] ADDR_MTVAL     = 12'h343;
   localparam logic [11:0] ADDR_MIP       = 12'h344;
   localparam logic [11:0] READ_ONLY_BASE = 12'hC00;

   localparam logic [2:0] CAUSE_INST_ALIGN  = 3'd0;
   localparam logic [2:0] CAUSE_LOAD_ALIGN  = 3'd4;
   localparam logic [2:0] CAUSE_STORE_ALIGN = 3'd6;

   localparam logic [1:0] MODE_DIRECT   = 2'd0;
   localparam logic [1:0] MODE_VECTORED = 2'd1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [11:0] csr_address;
      logic [31:0] write_value;
      logic [31:0] current_pc;
      logic [31:0] fault_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        csr_found;
      logic [31:0] next_pc;
   } rsp_type;

   typedef struct packed {
      logic        csr_access;
      op_type      csr_op;
      logic        trap;
      logic        tick;
      logic [2:0]  cause;
      logic [31:0] epc;
      logic [31:0] tval;
      logic [11:0] csr_address;
      logic [31:0] write_value;
      logic [31:0] current_pc;
   } ctl_type;

endpackage

### hdl/mcsr_decode.sv
// Request decoder that turns a registered request into control for the CSR file.
module mcsr_decode (
   input  logic              valid,
   input  mcsr_pkg::req_type req,
   output mcsr_pkg::ctl_type ctl
);

   always_comb begin
      ctl             = '0;
      ctl.csr_op      = mcsr_pkg::OP_RW;
      ctl.csr_address = req.csr_address;
      ctl.write_value = req.write_value;
      ctl.current_pc  = req.current_pc;
      unique case (mcsr_pkg::op_type'(req.operation)) inside
         mcsr_pkg::OP_RW, mcsr_pkg::OP_RS, mcsr_pkg::OP_RC: begin
            ctl.csr_access = valid;
            ctl.csr_op     = mcsr_pkg::op_type'(req.operation);
         end
         mcsr_pkg::OP_INST_ALIGN: begin
            ctl.trap  = valid;
            ctl.cause = mcsr_pkg::CAUSE_INST_ALIGN;
            ctl.epc   = req.fault_value;
            ctl.tval  = req.current_pc;
         end
         mcsr_pkg::OP_LOAD_ALIGN: begin
            ctl.trap  = valid;
            ctl.cause = mcsr_pkg::CAUSE_LOAD_ALIGN;
            ctl.epc   = req.current_pc;
            ctl.tval  = req.fault_value;
         end
         mcsr_pkg::OP_STORE_ALIGN: begin
            ctl.trap  = valid;
            ctl.cause = mcsr_pkg::CAUSE_STORE_ALIGN;
            ctl.epc   = req.current_pc;
            ctl.tval  = req.fault_value;
         end
         mcsr_pkg::OP_TICK: begin
            ctl.tick = valid;
         end
         default: begin
            ctl.tick = 1'b0;
         end
      endcase
   end

endmodule

### hdl/mcsr_regs.sv
// Machine CSR registers with read-modify-write, trap entry and the cycle counter.
module mcsr_regs (
   input  logic              clock,
   input  logic              reset,
   input  mcsr_pkg::ctl_type ctl,
   output mcsr_pkg::rsp_type rsp
);

   logic [63:0] cycle_ff, cycle_in;
   logic [31:0] mstatus_ff, mstatus_in;
   logic [31:0] misa_ff, misa_in;
   logic [31:0] mtvec_ff, mtvec_in;
   logic [31:0] mscratch_ff, mscratch_in;
   logic [31:0] mepc_ff, mepc_in;
   logic [31:0] mcause_ff, mcause_in;
   logic [31:0] mtval_ff, mtval_in;
   logic [31:0] mip_ff, mip_in;

   logic [31:0] old_value;
   logic [31:0] new_value;
   logic [31:0] trap_base;
   logic [31:0] trap_pc;
   logic        hit;
   logic        plain_hit;
   logic        write_en;

   always_comb begin
      old_value = '0;
      hit       = 1'b1;
      plain_hit = 1'b1;
      unique case (ctl.csr_address)
         mcsr_pkg::ADDR_MSTATUS:  old_value = mstatus_ff;
         mcsr_pkg::ADDR_MISA:     old_value = misa_ff;
         mcsr_pkg::ADDR_MTVEC:    old_value = mtvec_ff;
         mcsr_pkg::ADDR_MSCRATCH: old_value = mscratch_ff;
         mcsr_pkg::ADDR_MEPC:     old_value = mepc_ff;
         mcsr_pkg::ADDR_MCAUSE:   old_value = mcause_ff;
         mcsr_pkg::ADDR_MTVAL:    old_value = mtval_ff;
         mcsr_pkg::ADDR_MIP:      old_value = mip_ff;
         mcsr_pkg::ADDR_CYCLE: begin
            old_value = cycle_ff[31:0];
            plain_hit = 1'b0;
         end
         mcsr_pkg::ADDR_CYCLEH: begin
            old_value = cycle_ff[63:32];
            plain_hit = 1'b0;
         end
         default: begin
            hit       = 1'b0;
            plain_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (ctl.csr_op)
         mcsr_pkg::OP_RS: new_value = old_value | ctl.write_value;
         mcsr_pkg::OP_RC: new_value = old_value & ~ctl.write_value;
         default:         new_value = ctl.write_value;
      endcase
   end

   assign write_en  = ctl.csr_access && plain_hit && (ctl.csr_address < mcsr_pkg::READ_ONLY_BASE);
   assign trap_base = {mtvec_ff[31:2], 2'b00};

   always_comb begin
      case (mtvec_ff[1:0])
         mcsr_pkg::MODE_DIRECT:   trap_pc = trap_base;
         mcsr_pkg::MODE_VECTORED: trap_pc = trap_base + {27'd0, ctl.cause, 2'b00};
         default:                 trap_pc = ctl.current_pc;
      endcase
   end

   always_comb begin
      rsp.read_value = ctl.csr_access && hit ? old_value : '0;
      rsp.csr_found  = ctl.csr_access && hit;
      rsp.next_pc    = ctl.trap ? trap_pc : ctl.current_pc;
   end

   always_comb begin
      cycle_in    = ctl.tick ? cycle_ff + 64'd1 : cycle_ff;
      mstatus_in  = mstatus_ff;
      misa_in     = misa_ff;
      mtvec_in    = mtvec_ff;
      mscratch_in = mscratch_ff;
      mepc_in     = mepc_ff;
      mcause_in   = mcause_ff;
      mtval_in    = mtval_ff;
      mip_in      = mip_ff;
      if (write_en) begin
         unique case (ctl.csr_address)
            mcsr_pkg::ADDR_MSTATUS:  mstatus_in  = new_value;
            mcsr_pkg::ADDR_MISA:     misa_in     = new_value;
            mcsr_pkg::ADDR_MTVEC:    mtvec_in    = new_value;
            mcsr_pkg::ADDR_MSCRATCH: mscratch_in = new_value;
            mcsr_pkg::ADDR_MEPC:     mepc_in     = new_value;
            mcsr_pkg::ADDR_MCAUSE:   mcause_in   = new_value;
            mcsr_pkg::ADDR_MTVAL:    mtval_in    = new_value;
            mcsr_pkg::ADDR_MIP:      mip_in      = new_value;
            default:                 mip_in      = mip_ff;
         endcase
      end
      if (ctl.trap) begin
         mepc_in   = ctl.epc;
         mtval_in  = ctl.tval;
         mcause_in = {29'd0, ctl.cause};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff    <= '0;
         mstatus_ff  <= '0;
         misa_ff     <= '0;
         mtvec_ff    <= '0;
         mscratch_ff <= '0;
         mepc_ff     <= '0;
         mcause_ff   <= '0;
         mtval_ff    <= '0;
         mip_ff      <= '0;
      end else begin
         cycle_ff    <= cycle_in;
         mstatus_ff  <= mstatus_in;
         misa_ff     <= misa_in;
         mtvec_ff    <= mtvec_in;
         mscratch_ff <= mscratch_in;
         mepc_ff     <= mepc_in;
         mcause_ff   <= mcause_in;
         mtval_ff    <= mtval_in;
         mip_ff      <= mip_in;
      end
   end

endmodule

### hdl/machine_csr_file_with_trap_entry_top.sv
// Top level of the machine CSR file with misaligned-trap entry and cycle counter.
//
// A request is a transfer when start is high and busy is low at a rising clock edge.
// The request carries a CSR read-write, read-set or read-clear, a misaligned trap
// entry for an instruction, load or store, or a tick of the 64-bit cycle counter.
// Each request yields exactly one result: rsp_valid is high for one cycle and the
// result transfer completes at the edge that ends that cycle.
// The request is held in an input register, decoded and applied to the CSRs, and
// the result is captured in an output register that drives rsp_valid.
// A new request may be given in any cycle in which busy is low; throughput is one
// request per clock, set by the single read-modify-write pass through the CSR file.
// Requests see the CSR state left by all earlier requests, in order.
// A synchronous reset clears every CSR and the cycle counter, drops any request in
// flight, and holds busy high for the cycle after reset is released.
// The receiver cannot stall results, so there is no backpressure path.
`include "machine_csr_file_with_trap_entry_top_assert.svh"

module machine_csr_file_with_trap_entry_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mcsr_pkg::req_type req_payload,
   output logic              rsp_valid,
   output mcsr_pkg::rsp_type rsp_payload
);

   logic              busy_ff;
   logic              req_valid_ff, req_valid_in;
   mcsr_pkg::req_type req_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   mcsr_pkg::rsp_type rsp_ff;
   mcsr_pkg::ctl_type ctl;
   mcsr_pkg::rsp_type rsp_next;

   assign busy         = busy_ff;
   assign req_valid_in = start && !busy_ff;
   assign rsp_valid_in = req_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   mcsr_decode u_decode (
      .valid (req_valid_ff),
      .req   (req_ff),
      .ctl   (ctl)
   );

   mcsr_regs u_regs (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid_in) begin
         req_ff <= req_payload;
      end
      rsp_ff <= rsp_next;
   end

   `MCSR_ASSERT_TWO(a_req_gives_rsp, clock, reset, start && !busy, rsp_valid,
      "Accepted request did not produce a result two cycles later.")
   `MCSR_ASSERT_NEXT(a_trap_no_csr, clock, reset, ctl.trap,
      rsp_valid && !rsp_payload.csr_found && rsp_payload.read_value == 32'd0,
      "Trap entry result reported a CSR read.")
   `MCSR_ASSERT_SAME(a_found_needs_access, clock, reset, ctl.trap || ctl.tick,
      !rsp_next.csr_found && !ctl.csr_access,
      "Trap or tick decoded together with a CSR access.")

endmodule
